// ----- rtl/multi_servo_slew_limiter_unit_macros.svh -----
`ifndef MULTI_SERVO_SLEW_LIMITER_UNIT_MACROS_SVH
`define MULTI_SERVO_SLEW_LIMITER_UNIT_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define MSL_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define MSL_CHECK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define MSL_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/msl_pkg.sv -----
`default_nettype none

package msl_pkg;

    localparam int ANGLE_W     = 16;
    localparam int STEP_W      = 15;
    localparam int LEG_IDX_W   = 3;
    localparam int MODE_W      = 3;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MODE_W-1:0] MODE_TICK        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET_CUR_ABS = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET_CUR_REL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_DES_ABS = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET_DES_REL = 3'd4;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_SET_CUR = 2'd1;
    localparam logic [1:0] OP_SET_DES = 2'd2;

    typedef struct packed {
        logic [1:0]                op;
        logic                      rel;
        logic [LEG_IDX_W-1:0]      leg;
        logic signed [ANGLE_W-1:0] coxa;
        logic signed [ANGLE_W-1:0] tibia;
        logic [STEP_W-1:0]         step;
    } msl_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/multi_servo_slew_limiter_unit.sv -----
`default_nettype none
// Channel   Group      Contents
// input     s_*        mode in tuser; leg, coxa, tibia, step in tdata
// output    m_*        leg, joint, angle in tdata; last result of a word in tlast
//
// The front stage decodes one word per cycle while the command queue has room.
// A tick walks all LEGS*JOINTS entries, one per cycle unless stalled, then flushes.
// A set-current walks the JOINTS entries of its leg and flushes; a set-desired only walks.
// A full output register stalls the walker on the next reported joint only.
// Reset clears all angles and steps to zero; no clearing pass is needed.
module multi_servo_slew_limiter_unit
    import msl_pkg::*;
#(
    parameter int LEGS   = 6,
    parameter int JOINTS = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [2:0] leg_index, [18:3] coxa_angle, [34:19] tibia_angle, [50:35] step_size
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] mode
    input  wire logic [MODE_W-1:0]    s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [2:0] out_leg, [3] out_joint, [19:4] out_angle
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    logic     fe_valid, fe_ready;
    msl_cmd_t fe_cmd;
    logic     q_valid, q_pop;
    msl_cmd_t q_cmd;

    msl_front #(
        .LEGS (LEGS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (fe_valid),
        .cmd       (fe_cmd),
        .cmd_ready (fe_ready)
    );

    msl_queue #(
        .WIDTH ($bits(msl_cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fe_valid),
        .push_ready (fe_ready),
        .din        (fe_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .dout       (q_cmd)
    );

    msl_back #(
        .LEGS   (LEGS),
        .JOINTS (JOINTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/msl_front.sv -----
`default_nettype none

module msl_front
    import msl_pkg::*;
#(
    parameter int LEGS = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [2:0] leg_index, [18:3] coxa_angle, [34:19] tibia_angle, [50:35] step_size
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] mode
    input  wire logic [MODE_W-1:0]    s_tuser,
    output logic                      cmd_valid,
    output msl_cmd_t                  cmd,
    input  wire logic                 cmd_ready
);

    logic     cmd_valid_reg, cmd_valid_next;
    msl_cmd_t cmd_reg, cmd_next;

    logic [MODE_W-1:0]         mode;
    logic [LEG_IDX_W-1:0]      leg;
    logic signed [ANGLE_W-1:0] step_in;
    logic [ANGLE_W-1:0]        step_neg;
    logic                      leg_ok;
    logic                      keep;
    msl_cmd_t                  decoded;

    assign mode     = s_tuser;
    assign leg      = s_tdata[2:0];
    assign step_in  = s_tdata[50:35];
    assign step_neg = ~step_in + 16'd1;
    assign leg_ok   = (32'(leg) < LEGS);

    assign s_tready = !cmd_valid_reg || cmd_ready;

    always_comb
    begin
        decoded.op    = OP_TICK;
        decoded.rel   = 1'b0;
        decoded.leg   = leg;
        decoded.coxa  = s_tdata[18:3];
        decoded.tibia = s_tdata[34:19];
        // magnitude of the step, most negative value clips to the largest positive
        if (step_in == 16'sh8000)
            decoded.step = 15'h7fff;
        else if (step_in[15])
            decoded.step = step_neg[14:0];
        else
            decoded.step = step_in[14:0];

        keep = 1'b0;
        if (mode == MODE_TICK)
        begin
            keep = 1'b1;
        end
        else if (mode inside {MODE_SET_CUR_ABS, MODE_SET_CUR_REL})
        begin
            decoded.op  = OP_SET_CUR;
            decoded.rel = (mode == MODE_SET_CUR_REL);
            keep        = leg_ok;
        end
        else if (mode inside {MODE_SET_DES_ABS, MODE_SET_DES_REL})
        begin
            decoded.op  = OP_SET_DES;
            decoded.rel = (mode == MODE_SET_DES_REL);
            keep        = leg_ok;
        end
    end

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg && !cmd_ready;
        cmd_next       = cmd_reg;
        // drop words with an unknown mode, and set words with a leg out of range
        if (s_tvalid && s_tready && keep)
        begin
            cmd_valid_next = 1'b1;
            cmd_next       = decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else
            cmd_valid_reg <= cmd_valid_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

// ----- rtl/msl_queue.sv -----
`default_nettype none
`include "multi_servo_slew_limiter_unit_macros.svh"

module msl_queue
    import msl_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] din,
    output logic                  pop_valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign dout       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

    `MSL_CHECK(a_count_bound, 32'(count_reg) <= DEPTH, "queue count beyond depth")
    `MSL_CHECK_IMPL(a_empty_ptrs, count_reg == '0, rd_ptr_reg == wr_ptr_reg, "empty queue with split pointers")

endmodule

`default_nettype wire

// ----- rtl/msl_back.sv -----
`default_nettype none
`include "multi_servo_slew_limiter_unit_macros.svh"

module msl_back
    import msl_pkg::*;
#(
    parameter int LEGS   = 6,
    parameter int JOINTS = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire msl_cmd_t             q_cmd,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [2:0] out_leg, [3] out_joint, [19:4] out_angle
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    localparam int N     = LEGS * JOINTS;
    localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
    localparam int LEG_W = (LEGS > 1) ? $clog2(LEGS) : 1;
    localparam int JNT_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N - 1);
    localparam logic [JNT_W-1:0] LAST_JNT = JNT_W'(JOINTS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TICK  = 3'd1;
    localparam logic [2:0] ST_SETC  = 3'd2;
    localparam logic [2:0] ST_SETD  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    function automatic logic signed [ANGLE_W-1:0] sat16(input logic signed [ANGLE_W:0] v);
        if (v > 17'sd32767)
            return 16'sh7fff;
        else if (v < -17'sd32768)
            return 16'sh8000;
        else
            return signed'(v[ANGLE_W-1:0]);
    endfunction

    logic signed [ANGLE_W-1:0] cur_reg [N];
    logic signed [ANGLE_W-1:0] tgt_reg [N];
    logic [STEP_W-1:0]         step_reg [LEGS];

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [LEG_W-1:0] leg_reg, leg_next;
    logic [JNT_W-1:0] jnt_reg, jnt_next;

    logic                      rel_reg, rel_next;
    logic signed [ANGLE_W-1:0] coxa_reg, coxa_next;
    logic signed [ANGLE_W-1:0] tibia_reg, tibia_next;
    logic [STEP_W-1:0]         stepv_reg, stepv_next;

    logic                      pend_valid_reg, pend_valid_next;
    logic [LEG_IDX_W-1:0]      pend_leg_reg, pend_leg_next;
    logic                      pend_jnt_reg, pend_jnt_next;
    logic signed [ANGLE_W-1:0] pend_angle_reg, pend_angle_next;

    logic                      out_valid_reg, out_valid_next;
    logic [LEG_IDX_W-1:0]      out_leg_reg, out_leg_next;
    logic                      out_jnt_reg, out_jnt_next;
    logic signed [ANGLE_W-1:0] out_angle_reg, out_angle_next;
    logic                      out_last_reg, out_last_next;

    logic                      out_free;
    logic                      push_out, push_last;
    logic                      wr_en, step_wr;
    logic signed [ANGLE_W-1:0] cur_sel, tgt_sel, val_sel;
    logic signed [ANGLE_W:0]   err, s17, neg_s17, dec_cur, inc_cur;
    logic signed [ANGLE_W:0]   cur_sum, tgt_sum;
    logic signed [ANGLE_W-1:0] tick_new, setc_new, setd_new;
    logic signed [ANGLE_W-1:0] new_cur, new_tgt;
    logic                      tick_emit, emit, advance, done;
    logic [7:0]                leg_wide;
    logic [LEG_W-1:0]          q_leg;
    logic [IDX_W-1:0]          q_base;

    assign out_free = !out_valid_reg || m_tready;
    assign cur_sel  = cur_reg[idx_reg];
    assign tgt_sel  = tgt_reg[idx_reg];
    assign leg_wide = 8'(leg_reg);
    assign q_leg    = LEG_W'(q_cmd.leg);
    assign q_base   = IDX_W'(32'(q_cmd.leg) * JOINTS);

    always_comb
    begin
        if (jnt_reg == '0)
            val_sel = coxa_reg;
        else if (JOINTS > 1 && jnt_reg == JNT_W'(1))
            val_sel = tibia_reg;
        else
            val_sel = '0;
    end

    // slew step toward the target, or snap when within one step; also the absolute or relative set values
    always_comb
    begin
        err     = {cur_sel[ANGLE_W-1], cur_sel} - {tgt_sel[ANGLE_W-1], tgt_sel};
        s17     = signed'({2'b00, step_reg[leg_reg]});
        neg_s17 = -s17;
        dec_cur = {cur_sel[ANGLE_W-1], cur_sel} - s17;
        inc_cur = {cur_sel[ANGLE_W-1], cur_sel} + s17;
        if (err > s17)
        begin
            tick_new  = dec_cur[ANGLE_W-1:0];
            tick_emit = 1'b1;
        end
        else if (err < neg_s17)
        begin
            tick_new  = inc_cur[ANGLE_W-1:0];
            tick_emit = 1'b1;
        end
        else
        begin
            tick_new  = tgt_sel;
            tick_emit = 1'b0;
        end
        cur_sum  = {cur_sel[ANGLE_W-1], cur_sel} + {val_sel[ANGLE_W-1], val_sel};
        tgt_sum  = {tgt_sel[ANGLE_W-1], tgt_sel} + {val_sel[ANGLE_W-1], val_sel};
        setc_new = rel_reg ? sat16(cur_sum) : val_sel;
        setd_new = rel_reg ? sat16(tgt_sum) : val_sel;
    end

    always_comb
    begin
        case (state_reg)
            ST_TICK:
            begin
                new_cur = tick_new;
                new_tgt = tgt_sel;
            end
            ST_SETC:
            begin
                new_cur = setc_new;
                new_tgt = setc_new;
            end
            ST_SETD:
            begin
                new_cur = cur_sel;
                new_tgt = setd_new;
            end
            default:
            begin
                new_cur = cur_sel;
                new_tgt = tgt_sel;
            end
        endcase
    end

    assign emit    = (state_reg == ST_TICK && tick_emit) || state_reg == ST_SETC;
    assign advance = !(emit && pend_valid_reg && !out_free);
    assign done    = (state_reg == ST_TICK) ? (idx_reg == LAST_IDX) : (jnt_reg == LAST_JNT);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        leg_next        = leg_reg;
        jnt_next        = jnt_reg;
        rel_next        = rel_reg;
        coxa_next       = coxa_reg;
        tibia_next      = tibia_reg;
        stepv_next      = stepv_reg;
        pend_valid_next = pend_valid_reg;
        pend_leg_next   = pend_leg_reg;
        pend_jnt_next   = pend_jnt_reg;
        pend_angle_next = pend_angle_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        step_wr         = 1'b0;
        push_out        = 1'b0;
        push_last       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    rel_next   = q_cmd.rel;
                    coxa_next  = q_cmd.coxa;
                    tibia_next = q_cmd.tibia;
                    stepv_next = q_cmd.step;
                    jnt_next   = '0;
                    case (q_cmd.op)
                        OP_TICK:
                        begin
                            state_next = ST_TICK;
                            idx_next   = '0;
                            leg_next   = '0;
                        end
                        OP_SET_CUR:
                        begin
                            state_next = ST_SETC;
                            idx_next   = q_base;
                            leg_next   = q_leg;
                        end
                        OP_SET_DES:
                        begin
                            state_next = ST_SETD;
                            idx_next   = q_base;
                            leg_next   = q_leg;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TICK, ST_SETC, ST_SETD:
            begin
                if (advance)
                begin
                    wr_en   = 1'b1;
                    step_wr = (state_reg == ST_SETD);
                    if (emit)
                    begin
                        // earlier result goes out, not the final one
                        push_out        = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_leg_next   = leg_wide[LEG_IDX_W-1:0];
                        pend_jnt_next   = jnt_reg[0];
                        pend_angle_next = new_cur;
                    end
                    if (done)
                    begin
                        state_next = (state_reg == ST_SETD) ? ST_IDLE : ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (jnt_reg == LAST_JNT)
                        begin
                            jnt_next = '0;
                            leg_next = leg_reg + 1'b1;
                        end
                        else
                        begin
                            jnt_next = jnt_reg + 1'b1;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push_out        = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_leg_next   = out_leg_reg;
        out_jnt_next   = out_jnt_reg;
        out_angle_next = out_angle_reg;
        out_last_next  = out_last_reg;
        if (push_out)
        begin
            out_valid_next = 1'b1;
            out_leg_next   = pend_leg_reg;
            out_jnt_next   = pend_jnt_reg;
            out_angle_next = pend_angle_reg;
            out_last_next  = push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            leg_reg        <= '0;
            jnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                cur_reg[i] <= '0;
                tgt_reg[i] <= '0;
            end
            for (int i = 0; i < LEGS; i++)
            begin
                step_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            leg_reg        <= leg_next;
            jnt_reg        <= jnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (wr_en)
            begin
                cur_reg[idx_reg] <= new_cur;
                tgt_reg[idx_reg] <= new_tgt;
            end
            if (step_wr)
                step_reg[leg_reg] <= stepv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rel_reg        <= rel_next;
        coxa_reg       <= coxa_next;
        tibia_reg      <= tibia_next;
        stepv_reg      <= stepv_next;
        pend_leg_reg   <= pend_leg_next;
        pend_jnt_reg   <= pend_jnt_next;
        pend_angle_reg <= pend_angle_next;
        out_leg_reg    <= out_leg_next;
        out_jnt_reg    <= out_jnt_next;
        out_angle_reg  <= out_angle_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_angle_reg, out_jnt_reg, out_leg_reg};
    assign m_tlast  = out_last_reg;

    `MSL_CHECK_IMPL(a_idle_no_pend, state_reg == ST_IDLE, !pend_valid_reg, "pending result left in idle")
    `MSL_CHECK_IMPL(a_walk_index, state_reg == ST_TICK || state_reg == ST_SETC || state_reg == ST_SETD, 32'(idx_reg) == 32'(leg_reg) * JOINTS + 32'(jnt_reg), "entry index out of step with leg and joint")
    `MSL_CHECK_NEXT(a_flush_last, state_reg == ST_FLUSH && pend_valid_reg && out_free, out_valid_reg && out_last_reg, "final result not marked last")

endmodule

`default_nettype wire
